>>> sv/ep2rpm_pkg.sv
// Shared widths and constants for the edge period to rpm converter.
// No dependencies; imported by edge_period_to_rpm.
`timescale 1ns / 1ps

package ep2rpm_pkg;

  // Timestamps are carried in TIME_W bits, of which the low TIME_BITS are used.
  localparam int unsigned TIME_BITS = 63;
  localparam int unsigned TIME_W    = 63;
  localparam int unsigned LEN_W     = 64;
  localparam int unsigned PPR_W     = 16;
  localparam int unsigned PROD_W    = LEN_W + PPR_W;
  localparam int unsigned ALU_W     = PROD_W + 1;
  localparam int unsigned QUOT_W    = 64;
  localparam int unsigned CNT_W     = 6;

  localparam logic [TIME_W-1:0] TIME_MASK = TIME_W'((65'd1 << TIME_BITS) - 65'd1);

  // 1e15 fs/s * 60 s/min * 256 (8 fraction bits of rpm).
  localparam logic [QUOT_W-1:0] RPM_NUMERATOR = 64'd15360000000000000000;

  localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(1);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [LEN_W-1:0]  len_t;

endpackage

>>> sv/edge_period_to_rpm.sv
// Period measuring tachometer: pairs edge timestamps into full periods and
// converts each period to rpm with one shared adder/subtractor.
// Depends on ep2rpm_pkg.
`timescale 1ns / 1ps

// Sequence: an edge that closes a positive interval runs 16 multiply steps, 1 range check,
//   64 divide steps and 1 load; the divide is skipped when the product is too large, and a bad
//   interval goes straight to the load; the load waits while the output register stalls.
// Input stalls from a closing edge until its result is loaded, as the single 81-bit adder is
//   shared by the shift-add multiply and the restoring divide. Edges that close nothing do not stall.
// Reset: asynchronous, active low; clears pairing state and sets pulses per rev to 1.
module edge_period_to_rpm
  import ep2rpm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [PPR_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     new_capture_i,
  input  logic [TIME_W-1:0]        edge_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [TIME_W-1:0]        interval_start_o,
  output logic signed [LEN_W-1:0]  interval_length_o,
  output logic [QUOT_W-1:0]        speed_q8_o,
  output logic                     bad_interval_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PPR_W-1:0]   ppr_q;
  time_t              anchor_q, anchor_d;
  logic               have_anchor_q, have_anchor_d;
  logic               odd_q, odd_d;
  time_t              start_q, start_d;
  len_t               len_q, len_d;
  logic               bad_q, bad_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [QUOT_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0]  quot_q, quot_d;
  logic               out_valid_q, out_valid_d;
  time_t              out_start_q, out_start_d;
  len_t               out_len_q, out_len_d;
  logic [QUOT_W-1:0]  out_speed_q, out_speed_d;
  logic               out_bad_q, out_bad_d;

  logic               accept;
  time_t              t_in;
  logic [PPR_W-1:0]   ppr_eff;
  logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
  logic               alu_sub;
  logic               alu_neg;
  logic               out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign t_in     = edge_time_i & TIME_MASK;
  assign ppr_eff  = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // Shared unit: one 81-bit add or subtract per cycle.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_MUL: begin
        alu_a = {1'b0, prod_q[PROD_W-2:0], 1'b0};
        alu_b = ppr_eff[cnt_q[3:0]] ? ALU_W'(len_q) : '0;
      end
      ST_CHK: begin
        alu_a   = ALU_W'(RPM_NUMERATOR);
        alu_b   = ALU_W'(prod_q);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = ALU_W'({rem_q, quot_q[QUOT_W-1]});
        alu_b   = ALU_W'(prod_q[QUOT_W-1:0]);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign alu_neg = alu_sum[ALU_W-1];

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    anchor_d      = anchor_q;
    have_anchor_d = have_anchor_q;
    odd_d         = odd_q;
    start_d       = start_q;
    len_d         = len_q;
    bad_d         = bad_q;
    prod_d        = prod_q;
    rem_d         = rem_q;
    quot_d        = quot_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_start_d   = out_start_q;
    out_len_d     = out_len_q;
    out_speed_d   = out_speed_q;
    out_bad_d     = out_bad_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (new_capture_i || !have_anchor_q) begin
            anchor_d      = t_in;
            have_anchor_d = 1'b1;
            odd_d         = 1'b0;
          end else if (!odd_q) begin
            odd_d = 1'b1;
          end else begin
            // Both timestamps are below 2^63, so the wrapped difference is exact.
            start_d  = anchor_q;
            len_d    = {1'b0, t_in} - {1'b0, anchor_q};
            bad_d    = (t_in <= anchor_q);
            anchor_d = t_in;
            odd_d    = 1'b0;
            prod_d   = '0;
            quot_d   = '0;
            cnt_d    = CNT_W'(PPR_W - 1);
            state_d  = (t_in <= anchor_q) ? ST_DONE : ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_d = alu_sum[PROD_W-1:0];
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        // A product above the numerator gives speed zero.
        if (alu_neg) begin
          quot_d  = '0;
          state_d = ST_DONE;
        end else begin
          rem_d   = '0;
          quot_d  = RPM_NUMERATOR;
          cnt_d   = CNT_W'(QUOT_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = alu_neg ? {rem_q[QUOT_W-2:0], quot_q[QUOT_W-1]} : alu_sum[QUOT_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], !alu_neg};
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_start_d = start_q;
          out_len_d   = len_q;
          out_speed_d = quot_q;
          out_bad_d   = bad_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      ppr_q         <= PPR_RESET;
      anchor_q      <= '0;
      have_anchor_q <= 1'b0;
      odd_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      anchor_q      <= anchor_d;
      have_anchor_q <= have_anchor_d;
      odd_q         <= odd_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        ppr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    len_q       <= len_d;
    bad_q       <= bad_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    quot_q      <= quot_d;
    out_start_q <= out_start_d;
    out_len_q   <= out_len_d;
    out_speed_q <= out_speed_d;
    out_bad_q   <= out_bad_d;
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign interval_start_o  = out_start_q;
  assign interval_length_o = out_len_q;
  assign speed_q8_o        = out_speed_q;
  assign bad_interval_o    = out_bad_q;

`ifndef NO_ASSERTIONS
  a_bad_speed_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_interval_o |-> speed_q8_o == '0)
    else $error("bad interval with nonzero speed");

  a_bad_matches_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bad_interval_o == (interval_length_o <= 0))
    else $error("bad flag disagrees with interval length");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < prod_q[QUOT_W-1:0])
    else $error("divider remainder not below divisor");

  a_done_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_o && state_q == ST_IDLE)
    else $error("finished result not loaded into output register");
`endif

endmodule
